[rtl/core/tmsbld_pkg.sv]
// ----------------------------------------------------------------------------
// tmsbld_pkg
// Shared types and constants of the two-mode signal bit-line decoder.
// ----------------------------------------------------------------------------
package tmsbld_pkg;

  localparam int unsigned LineDepthDef   = 63;
  localparam logic [15:0] ThresholdReset = 16'd1300;
  localparam logic [7:0]  NewlineByte    = 8'd10;
  localparam logic [7:0]  PrintLow       = 8'd31;
  localparam logic [7:0]  PrintHigh      = 8'd127;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_INTERVAL = 2'd1,
    MODE_SYMBOL   = 2'd2
  } mode_e;

  typedef enum logic {
    RES_VERDICT = 1'b0,
    RES_CHAR    = 1'b1
  } res_kind_e;

  typedef struct packed {
    logic        signal_kind;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        line_ok;
    logic [7:0]  char_value;
    logic        last;
  } out_item_t;

  // printable or newline
  function automatic logic byte_fits(input logic [7:0] b);
    byte_fits = (b == NewlineByte) || ((b > PrintLow) && (b < PrintHigh));
  endfunction

endpackage

[rtl/core/tmsbld_ram.sv]
// ----------------------------------------------------------------------------
// tmsbld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmsbld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/two_mode_signal_bit_line_decoder_core.sv]
// ----------------------------------------------------------------------------
// two_mode_signal_bit_line_decoder_core
// Decodes signal events into bits and bytes, buffers a line in RAM and
// replays it with a leading verdict once a newline byte completes.
// ----------------------------------------------------------------------------
// An event is taken while idle; events that do not end a line give no item.
// A newline stalls the input: one verdict item, then one character item per
// cycle out of the line RAM, whose read port is registered, while the output
// is not stalled.
// Reset clears mode, bit and line state; the threshold resets to 1300.
// The line RAM is not cleared; only entries below the line length are read.
module two_mode_signal_bit_line_decoder_core #(
  parameter int unsigned LINE_DEPTH = tmsbld_pkg::LineDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tmsbld_pkg::in_item_t  in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tmsbld_pkg::out_item_t out_o
);
  import tmsbld_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam logic [LW-1:0] LenFull  = LW'(LINE_DEPTH - 1);
  localparam logic [LW-1:0] LenLimit = LW'(LINE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_VERDICT = 3'b010,
    ST_REPLAY  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] thr_q;
  mode_e       mode_q, mode_d;
  logic        pair_open_q, pair_open_d;
  logic [31:0] pair_start_q, pair_start_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  accum_q, accum_d;
  logic [LW-1:0] len_q, len_d;
  logic        bad_q, bad_d;
  logic [LW-1:0] rd_cnt_q, rd_cnt_d;
  logic        pend_q, pend_d;
  logic        pend_last_q, pend_last_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        accept;
  logic        bit_valid;
  logic        bit_val;
  logic [31:0] gap;
  logic [7:0]  byte_new;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic        out_free;
  logic        load_pend;
  logic        issue;
  logic [7:0]  rd_data;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign gap        = in_i.time_us - pair_start_q;
  assign byte_new   = accum_q | (8'h80 >> bit_cnt_q);
  assign wr_addr    = len_q[AW-1:0];

  assign load_pend  = (state_q == ST_REPLAY) && pend_q && out_free;
  assign issue      = (state_q == ST_REPLAY) && (rd_cnt_q != len_q)
                      && (!pend_q || load_pend);

  always_comb begin
    mode_d       = mode_q;
    pair_open_d  = pair_open_q;
    pair_start_d = pair_start_q;
    bit_cnt_d    = bit_cnt_q;
    accum_d      = accum_q;
    len_d        = len_q;
    bad_d        = bad_q;
    state_d      = state_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    wr_en        = 1'b0;
    bit_valid    = 1'b0;
    bit_val      = 1'b0;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // bit decode
    if (accept) begin
      unique case (mode_q)
        MODE_NONE: begin
          mode_d = in_i.signal_kind ? MODE_SYMBOL : MODE_INTERVAL;
        end
        MODE_INTERVAL: begin
          if (!pair_open_q) begin
            pair_open_d  = 1'b1;
            pair_start_d = in_i.time_us;
          end else begin
            pair_open_d = 1'b0;
            bit_valid   = 1'b1;
            bit_val     = (gap > {16'd0, thr_q});
          end
        end
        MODE_SYMBOL: begin
          bit_valid = 1'b1;
          bit_val   = in_i.signal_kind;
        end
        default: ;
      endcase
    end

    // byte assembly and line store
    if (bit_valid) begin
      bit_cnt_d = bit_cnt_q + 3'd1;
      accum_d   = bit_val ? byte_new : accum_q;
      if (bit_cnt_q == 3'd7) begin
        accum_d = 8'd0;
      end
    end
    if (bit_valid && bit_cnt_q == 3'd7) begin
      if ((bit_val ? byte_new : accum_q) != NewlineByte) begin
        if (len_q < LenFull) begin
          wr_en = 1'b1;
          len_d = len_q + LW'(1);
          if (!byte_fits(bit_val ? byte_new : accum_q)) begin
            bad_d = 1'b1;
          end
        end else begin
          bad_d = 1'b1;
        end
      end else begin
        if (len_q < LenLimit) begin
          wr_en = 1'b1;
          len_d = len_q + LW'(1);
        end
        state_d = ST_VERDICT;
      end
    end

    // verdict and replay
    unique case (state_q)
      ST_IDLE: ;
      ST_VERDICT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = RES_VERDICT;
          out_d.line_ok     = !bad_q;
          out_d.char_value  = 8'd0;
          out_d.last        = 1'b0;
          rd_cnt_d          = '0;
          pend_d            = 1'b0;
          state_d           = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (load_pend) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = RES_CHAR;
          out_d.line_ok     = !bad_q;
          out_d.char_value  = rd_data;
          out_d.last        = pend_last_q;
          pend_d            = 1'b0;
          if (pend_last_q) begin
            len_d   = '0;
            bad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
        if (issue) begin
          pend_d      = 1'b1;
          pend_last_d = ((rd_cnt_q + LW'(1)) == len_q);
          rd_cnt_d    = rd_cnt_q + LW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  tmsbld_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(bit_val ? byte_new : accum_q),
    .re_i   (issue),
    .raddr_i(rd_cnt_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= ThresholdReset;
      mode_q       <= MODE_NONE;
      pair_open_q  <= 1'b0;
      pair_start_q <= '0;
      bit_cnt_q    <= '0;
      accum_q      <= '0;
      len_q        <= '0;
      bad_q        <= 1'b0;
      rd_cnt_q     <= '0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      mode_q       <= mode_d;
      pair_open_q  <= pair_open_d;
      pair_start_q <= pair_start_d;
      bit_cnt_q    <= bit_cnt_d;
      accum_q      <= accum_d;
      len_q        <= len_d;
      bad_q        <= bad_d;
      rd_cnt_q     <= rd_cnt_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/core/tmsbld_checker.sv]
// ----------------------------------------------------------------------------
// tmsbld_checker
// Port-level checks of the decoder core, bound to the core module.
// ----------------------------------------------------------------------------
module tmsbld_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input tmsbld_pkg::out_item_t out_o
);
  import tmsbld_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("output item changed under stall");

  // verdict carries no character and never ends the run
  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.result_kind == RES_VERDICT |->
      out_o.char_value == 8'd0 && !out_o.last)
    else $error("malformed verdict item");

  // the run always ends on the newline character
  a_last_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |->
      out_o.result_kind == RES_CHAR && out_o.char_value == NewlineByte)
    else $error("last item is not the newline");

  // no new event while a line is still being replayed
  a_replay_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> in_stall_o)
    else $error("input open during replay");

endmodule

bind two_mode_signal_bit_line_decoder_core tmsbld_checker u_tmsbld_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_o      (out_o)
);
